>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: invariant violated");
// Check that a consequence holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/mcsrb_pkg.sv
// Shared types, constants and helper functions of the serial ring buffers.
package mcsrb_pkg;

   localparam int RING_DEPTH   = 256;
   localparam int NUM_CHANNELS = 4;

   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int CH_W       = 2;
   localparam int BYTE_W     = 8;
   localparam int CMD_W      = 2;
   localparam int SIZE_W     = 9;
   localparam int CHAN_EN_W  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // ring select is {transmit, channel}
   localparam int RING_SEL_W = 1 + CH_W;
   localparam int RING_COUNT = 2 ** RING_SEL_W;
   localparam int MEM_AW     = RING_SEL_W + PTR_W;
   localparam int MEM_DEPTH  = 2 ** MEM_AW;

   localparam int QUEUE_DEPTH = 2;
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QIDX_W + 1;

   localparam logic [CMD_W-1:0] CMD_PUSH_RX = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP_RX  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PUSH_TX = 2'd2;
   localparam logic [CMD_W-1:0] CMD_POP_TX  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_RX_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TX_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAN_EN = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CH_W-1:0]   channel;
      logic [BYTE_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic              was_empty;
      logic              overflow;
      logic              rejected;
   } rsp_type;

   // classified request as it waits for the back end
   typedef struct packed {
      logic              rejected;
      logic              is_push;
      logic              is_tx;
      logic [CH_W-1:0]   channel;
      logic [BYTE_W-1:0] data_byte;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type work;
   } cmdq_type;

   // Clamp a size register into 1..RING_DEPTH.
   function automatic logic [PTR_W:0] eff_size(input logic [SIZE_W-1:0] size);
      logic [PTR_W:0] r;
      if (size == '0) begin
         r = (PTR_W+1)'(1);
      end else if (int'(size) > RING_DEPTH) begin
         r = (PTR_W+1)'(RING_DEPTH);
      end else begin
         r = (PTR_W+1)'(size);
      end
      return r;
   endfunction

   // Step a pointer, wrapping to zero at or beyond the ring size.
   function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] ptr,
                                                    input logic [PTR_W:0]   esize);
      logic [PTR_W:0] nxt;
      nxt = {1'b0, ptr} + (PTR_W+1)'(1);
      if (nxt >= esize) begin
         return '0;
      end
      return nxt[PTR_W-1:0];
   endfunction

endpackage

>>> hw/rtl/mcsrb_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module mcsrb_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  mcsrb_pkg::req_type                  req_data,
   output logic                                req_full,
   input  logic [mcsrb_pkg::CHAN_EN_W-1:0]     chan_en,
   output mcsrb_pkg::cmdq_type                 head,
   input  logic                                take
);
   import mcsrb_pkg::*;

   work_type          entry_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [QIDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   work_type          cls;
   logic              push_fire;
   logic              pop_fire;

   always_comb begin
      cls.rejected  = (int'(req_data.channel) >= NUM_CHANNELS) || !chan_en[req_data.channel];
      cls.is_push   = (req_data.cmd == CMD_PUSH_RX) || (req_data.cmd == CMD_PUSH_TX);
      cls.is_tx     = (req_data.cmd == CMD_PUSH_TX) || (req_data.cmd == CMD_POP_TX);
      cls.channel   = req_data.channel;
      cls.data_byte = req_data.data_byte;
   end

   assign req_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push_fire = req_push && !req_full;
   assign pop_fire  = take && (count_ff != '0);

   assign wr_idx_in = push_fire ? wr_idx_ff + QIDX_W'(1) : wr_idx_ff;
   assign rd_idx_in = pop_fire ? rd_idx_ff + QIDX_W'(1) : rd_idx_ff;
   assign count_in  = count_ff + QCNT_W'(push_fire) - QCNT_W'(pop_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_idx_ff] <= cls;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.work  = entry_ff[rd_idx_ff];

endmodule

>>> hw/rtl/mcsrb_back.sv
// Back end: ring pointers, byte store, result stage and result queue.
module mcsrb_back (
   input  logic                             clock,
   input  logic                             reset,
   input  mcsrb_pkg::cmdq_type              head,
   output logic                             take,
   input  logic [mcsrb_pkg::SIZE_W-1:0]     rx_size,
   input  logic [mcsrb_pkg::SIZE_W-1:0]     tx_size,
   input  logic                             rsp_pop,
   output logic                             rsp_empty,
   output mcsrb_pkg::rsp_type               rsp_data
);
   import mcsrb_pkg::*;

   logic [PTR_W-1:0]      rd_ptr_ff [RING_COUNT];
   logic [PTR_W-1:0]      wr_ptr_ff [RING_COUNT];
   logic [BYTE_W-1:0]     mem [MEM_DEPTH];
   logic [BYTE_W-1:0]     mem_q_ff;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_use_mem_ff;
   rsp_type               s1_rsp_ff, s1_rsp_in;
   rsp_type               s1_out;

   rsp_type               out_entry_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0]     out_wr_idx_ff, out_wr_idx_in;
   logic [QIDX_W-1:0]     out_rd_idx_ff, out_rd_idx_in;
   logic [QCNT_W-1:0]     out_count_ff, out_count_in;

   logic [RING_SEL_W-1:0] sel;
   logic [PTR_W:0]        esize;
   logic [PTR_W-1:0]      rd_cur, wr_cur, rd_adv, wr_adv;
   logic                  ring_empty;
   logic [QCNT_W:0]       occ;
   logic                  pop_fire;
   logic                  issue;
   logic                  live;
   logic                  mem_we, mem_re;
   logic [MEM_AW-1:0]     mem_addr;

   // Issue only when the result stage plus queue keeps a free slot.
   assign pop_fire = rsp_pop && !rsp_empty;
   assign occ      = {1'b0, out_count_ff} + (QCNT_W+1)'(s1_valid_ff);
   assign issue    = head.valid &&
                     ((occ - (QCNT_W+1)'(pop_fire)) < (QCNT_W+1)'(QUEUE_DEPTH));
   assign take     = issue;

   assign sel        = {head.work.is_tx, head.work.channel};
   assign esize      = eff_size(head.work.is_tx ? tx_size : rx_size);
   assign rd_cur     = rd_ptr_ff[sel];
   assign wr_cur     = wr_ptr_ff[sel];
   assign ring_empty = (rd_cur == wr_cur);
   assign rd_adv     = ptr_advance(rd_cur, esize);
   assign wr_adv     = ptr_advance(wr_cur, esize);

   assign live     = issue && !head.work.rejected;
   assign mem_we   = live && head.work.is_push;
   assign mem_re   = live && !head.work.is_push && !ring_empty;
   assign mem_addr = {sel, head.work.is_push ? wr_cur : rd_cur};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_COUNT; i++) begin
            rd_ptr_ff[i] <= '0;
            wr_ptr_ff[i] <= '0;
         end
      end else begin
         if (mem_we) begin
            wr_ptr_ff[sel] <= wr_adv;
         end
         if (mem_re) begin
            rd_ptr_ff[sel] <= rd_adv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= head.work.data_byte;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_addr];
      end
   end

   always_comb begin
      s1_valid_in         = issue;
      s1_rsp_in.read_data = '0;
      s1_rsp_in.was_empty = !head.work.rejected && !head.work.is_push && ring_empty;
      s1_rsp_in.overflow  = !head.work.rejected && head.work.is_push && (wr_adv == rd_cur);
      s1_rsp_in.rejected  = head.work.rejected;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_rsp_ff     <= s1_rsp_in;
         s1_use_mem_ff <= mem_re;
      end
   end

   always_comb begin
      s1_out = s1_rsp_ff;
      if (s1_use_mem_ff) begin
         s1_out.read_data = mem_q_ff;
      end
   end

   assign out_wr_idx_in = s1_valid_ff ? out_wr_idx_ff + QIDX_W'(1) : out_wr_idx_ff;
   assign out_rd_idx_in = pop_fire ? out_rd_idx_ff + QIDX_W'(1) : out_rd_idx_ff;
   assign out_count_in  = out_count_ff + QCNT_W'(s1_valid_ff) - QCNT_W'(pop_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_idx_ff <= '0;
         out_rd_idx_ff <= '0;
         out_count_ff  <= '0;
      end else begin
         out_wr_idx_ff <= out_wr_idx_in;
         out_rd_idx_ff <= out_rd_idx_in;
         out_count_ff  <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         out_entry_ff[out_wr_idx_ff] <= s1_out;
      end
   end

   assign rsp_empty = (out_count_ff == '0);
   assign rsp_data  = out_entry_ff[out_rd_idx_ff];

endmodule

>>> hw/rtl/multi_channel_serial_ring_buffers.sv
// Top level of the four-channel serial receive/transmit ring buffers.
//
//   port group | direction | handshake            | payload
//   req_*      | in        | push / full          | req_data  (cmd, channel, data_byte)
//   rsp_*      | out       | empty / pop          | rsp_data  (read_data, flags)
//   csr_*      | in        | csr_we, no wait      | csr_index, csr_wdata
//
// One request per cycle is sustained while results are popped; once issued, an
// enabled push or non-empty pop makes one byte-store access and one ring pointer
// update. Reset is synchronous: pointers zero, queues empty, sizes 256, channels
// off; the byte store is not cleared, and reading it only where it was written is
// up to the user; the block leaves it unenforced. full rises at two queued requests;
// issue holds while two results wait unpopped.
`include "assert_macros.svh"

module multi_channel_serial_ring_buffers (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  mcsrb_pkg::req_type                   req_data,
   output logic                                 full,
   output logic                                 empty,
   input  logic                                 pop,
   output mcsrb_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_we,
   input  logic [mcsrb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mcsrb_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mcsrb_pkg::*;

   // requests anywhere inside: command queue, result stage, result queue
   localparam int INFLIGHT_W = $clog2(2 * QUEUE_DEPTH + 2);

   logic [SIZE_W-1:0]     rx_size_ff, rx_size_in;
   logic [SIZE_W-1:0]     tx_size_ff, tx_size_in;
   logic [CHAN_EN_W-1:0]  chan_en_ff, chan_en_in;
   logic [INFLIGHT_W-1:0] inflight_ff, inflight_in;

   cmdq_type              head;
   logic                  take;
   logic                  req_full;
   logic                  rsp_empty;
   logic                  req_fire;
   logic                  rsp_fire;
   logic [2:0]            rsp_flags;
   logic                  rsp_flagged;

   // Decode the register write; an index past the list is dropped.
   always_comb begin
      rx_size_in = rx_size_ff;
      tx_size_in = tx_size_ff;
      chan_en_in = chan_en_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RX_SIZE: rx_size_in = csr_wdata[SIZE_W-1:0];
            CSR_TX_SIZE: tx_size_in = csr_wdata[SIZE_W-1:0];
            CSR_CHAN_EN: chan_en_in = csr_wdata[CHAN_EN_W-1:0];
            default:     chan_en_in = chan_en_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_size_ff <= SIZE_RESET;
         tx_size_ff <= SIZE_RESET;
         chan_en_ff <= '0;
      end else begin
         rx_size_ff <= rx_size_in;
         tx_size_ff <= tx_size_in;
         chan_en_ff <= chan_en_in;
      end
   end

   // Classify and hold incoming requests.
   mcsrb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (push),
      .req_data (req_data),
      .req_full (req_full),
      .chan_en  (chan_en_ff),
      .head     (head),
      .take     (take)
   );

   // Carry out pushes and pops, then queue the results.
   mcsrb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .take      (take),
      .rx_size   (rx_size_ff),
      .tx_size   (tx_size_ff),
      .rsp_pop   (pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   assign full  = req_full;
   assign empty = rsp_empty;

   // Track requests between acceptance and delivery.
   assign req_fire    = push && !req_full;
   assign rsp_fire    = pop && !rsp_empty;
   assign inflight_in = inflight_ff + INFLIGHT_W'(req_fire) - INFLIGHT_W'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   assign rsp_flags   = {rsp_data.was_empty, rsp_data.overflow, rsp_data.rejected};
   assign rsp_flagged = !rsp_empty && (rsp_flags != '0);

   `ASSERT_IMPLIES(a_no_result_without_request, clock, reset, inflight_ff == '0, rsp_empty)
   `ASSERT_ALWAYS(a_inflight_bounded, clock, reset, inflight_ff <= INFLIGHT_W'(2 * QUEUE_DEPTH + 1))
   `ASSERT_IMPLIES(a_flags_exclusive, clock, reset, !rsp_empty, $onehot0(rsp_flags))
   `ASSERT_IMPLIES(a_no_data_without_pop, clock, reset, rsp_flagged, rsp_data.read_data == '0)

endmodule

>>> dv/ring_buffers_checker.sv
// Checker for the serial ring buffers: predicts every result and compares it when popped.
module ring_buffers_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   input  mcsrb_pkg::req_type               req_data,
   input  logic                             full,
   input  logic                             empty,
   input  logic                             pop,
   input  mcsrb_pkg::rsp_type               rsp_data,
   input  logic                             csr_we,
   input  logic [mcsrb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mcsrb_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                               fail_count,
   output int                               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import mcsrb_pkg::*;

   // index 0 is the receive side, 1 the transmit side
   logic [BYTE_W-1:0]    ring_bytes [2][NUM_CHANNELS][RING_DEPTH];
   logic [PTR_W-1:0]     rd_ptr [2][NUM_CHANNELS];
   logic [PTR_W-1:0]     wr_ptr [2][NUM_CHANNELS];
   logic [SIZE_W-1:0]    size_reg [2];
   logic [CHAN_EN_W-1:0] chan_en;
   rsp_type              due_outcomes[$];
   int                   mismatches = 0;

   function automatic int ring_limit(logic [SIZE_W-1:0] v);
      if (v == 0) begin
         return 1;
      end
      if (v > RING_DEPTH) begin
         return RING_DEPTH;
      end
      return int'(v);
   endfunction

   function automatic logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p, int lim);
      return (int'(p) + 1 >= lim) ? '0 : p + PTR_W'(1);
   endfunction

   // Apply one request to the predicted rings and return its result.
   function automatic rsp_type ring_outcome(req_type r);
      rsp_type o;
      int      side;
      int      ch;
      int      lim;
      o = '0;
      ch = int'(r.channel);
      if (ch >= NUM_CHANNELS || !chan_en[ch]) begin
         o.rejected = 1'b1;
         return o;
      end
      side = (r.cmd == CMD_PUSH_TX || r.cmd == CMD_POP_TX) ? 1 : 0;
      lim = ring_limit(size_reg[side]);
      if (r.cmd == CMD_PUSH_RX || r.cmd == CMD_PUSH_TX) begin
         ring_bytes[side][ch][wr_ptr[side][ch]] = r.data_byte;
         wr_ptr[side][ch] = step_ptr(wr_ptr[side][ch], lim);
         o.overflow = (wr_ptr[side][ch] == rd_ptr[side][ch]);
      end else if (rd_ptr[side][ch] == wr_ptr[side][ch]) begin
         o.was_empty = 1'b1;
      end else begin
         o.read_data = ring_bytes[side][ch][rd_ptr[side][ch]];
         rd_ptr[side][ch] = step_ptr(rd_ptr[side][ch], lim);
      end
      return o;
   endfunction

   task automatic check_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : track
      rsp_type want;
      if (reset) begin
         for (int s = 0; s < 2; s++) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               rd_ptr[s][c] = '0;
               wr_ptr[s][c] = '0;
            end
            size_reg[s] = SIZE_RESET;
         end
         chan_en = '0;
         due_outcomes.delete();
      end else begin
         // retire the result first: it belongs to an older request
         if (pop && !empty) begin
            if (due_outcomes.size() == 0) begin
               $error("result with no request waiting");
               mismatches++;
            end else begin
               want = due_outcomes.pop_front();
               check_field("read_data", want.read_data, rsp_data.read_data);
               check_field("was_empty", want.was_empty, rsp_data.was_empty);
               check_field("overflow", want.overflow, rsp_data.overflow);
               check_field("rejected", want.rejected, rsp_data.rejected);
            end
         end
         if (req_push && !full) begin
            due_outcomes.push_back(ring_outcome(req_data));
         end
         if (csr_we) begin
            case (csr_index)
               CSR_RX_SIZE: size_reg[0] = csr_wdata;
               CSR_TX_SIZE: size_reg[1] = csr_wdata;
               CSR_CHAN_EN: chan_en = csr_wdata[CHAN_EN_W-1:0];
               default: ;
            endcase
         end
      end
      fail_count <= mismatches;
      pending_count <= due_outcomes.size();
   end

endmodule

>>> dv/multi_channel_serial_ring_buffers_tb.sv
// Testbench top for the serial ring buffers: stimulus, idling, watchdog and verdict.
module multi_channel_serial_ring_buffers_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mcsrb_pkg::*;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int HOLD_CYCLES     = 60;    // long receiver hold-off to fill the block
   localparam int SETTLE_CYCLES   = 8;     // margin after the last result is back
   localparam int STALL_LIMIT     = 4000;  // cycles with no request or result moving

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   req_type               req_data;
   logic                  full;
   logic                  empty;
   logic                  pop;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending_count;

   // idling knobs, the rates in percent of cycles, and the watchdog count
   int send_gap_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_ask = 1'b0;
   int quiet_cycles = 0;

   // Mirror of the configuration and of the ring pointers (no data): enough
   // to know how many pops empty each ring before a size change.
   logic [SIZE_W-1:0]    size_mirror [2];
   logic [CHAN_EN_W-1:0] live_mask;
   int                   rd_at [2][NUM_CHANNELS];
   int                   wr_at [2][NUM_CHANNELS];

   multi_channel_serial_ring_buffers u_top (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .req_data  (req_data),
      .full      (full),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ring_buffers_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data      (req_data),
      .full          (full),
      .empty         (empty),
      .pop           (pop),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int ring_limit(logic [SIZE_W-1:0] v);
      if (v == 0) begin
         return 1;
      end
      return (v > RING_DEPTH) ? RING_DEPTH : int'(v);
   endfunction

   function automatic int slot_after(int p, int lim);
      return (p + 1 >= lim) ? 0 : p + 1;
   endfunction

   // Offer one request, idling first at the sender's rate; return at the
   // falling edge after it was taken, with push still high.
   task automatic offer(input logic [CMD_W-1:0] cmd, input int ch,
                        input logic [BYTE_W-1:0] data);
      req_type r;
      int      s;
      int      lim;
      r.cmd = cmd;
      r.channel = CH_W'(ch);
      r.data_byte = data;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (full);
      @(negedge clock);
      // advance the pointer mirror the way the block will
      if (live_mask[ch]) begin
         s = (cmd == CMD_PUSH_TX || cmd == CMD_POP_TX) ? 1 : 0;
         lim = ring_limit(size_mirror[s]);
         if (cmd == CMD_PUSH_RX || cmd == CMD_PUSH_TX) begin
            wr_at[s][ch] = slot_after(wr_at[s][ch], lim);
         end else if (rd_at[s][ch] != wr_at[s][ch]) begin
            rd_at[s][ch] = slot_after(rd_at[s][ch], lim);
         end
      end
   endtask

   // Drop push and hold until every expected result is back and the block is idle.
   task automatic settle();
      req_push <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_RX_SIZE: size_mirror[0] = val;
         CSR_TX_SIZE: size_mirror[1] = val;
         CSR_CHAN_EN: live_mask = val[CHAN_EN_W-1:0];
         default: ;
      endcase
   endtask

   // Pop every ring until its read pointer meets its write pointer.
   task automatic drain_rings();
      for (int s = 0; s < 2; s++) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            while (rd_at[s][c] != wr_at[s][c]) begin
               offer(s ? CMD_POP_TX : CMD_POP_RX, c, 8'h00);
            end
         end
      end
   endtask

   // Change sizes only on empty rings, so a pop never lands on a slot that
   // was never written; then set the channel mask.
   task automatic enter_phase(input logic [SIZE_W-1:0] rx, input logic [SIZE_W-1:0] tx,
                              input logic [CHAN_EN_W-1:0] mask);
      settle();
      write_csr(CSR_CHAN_EN, 9'h00F);
      drain_rings();
      settle();
      write_csr(CSR_RX_SIZE, rx);
      write_csr(CSR_TX_SIZE, tx);
      write_csr(CSR_CHAN_EN, CSR_DATA_W'(mask));
   endtask

   // Receiver: stall at the requested rate, or hold off for a long stretch on request.
   initial begin : receiver
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_ask) begin
            hold_ask = 1'b0;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            pop <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int                   ch;
      logic [SIZE_W-1:0]    rx_pick;
      logic [SIZE_W-1:0]    tx_pick;
      logic [CHAN_EN_W-1:0] mask_pick;

      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      size_mirror[0] = SIZE_RESET;
      size_mirror[1] = SIZE_RESET;
      live_mask = '0;
      for (int s = 0; s < 2; s++) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            rd_at[s][c] = 0;
            wr_at[s][c] = 0;
         end
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // all channels off after reset: both requests are rejected
      offer(CMD_PUSH_RX, 0, 8'hFF);
      offer(CMD_POP_TX, 3, 8'h00);
      settle();
      write_csr(CSR_CHAN_EN, 9'h00A);
      // channel 0 still off; channel 3 on: push, pop, then pop an empty ring
      offer(CMD_PUSH_RX, 0, 8'h00);
      offer(CMD_PUSH_TX, 3, 8'hFF);
      offer(CMD_POP_TX, 3, 8'h00);
      offer(CMD_POP_TX, 3, 8'hFF);
      settle();
      write_csr(CSR_CHAN_EN, 9'h00F);
      offer(CMD_PUSH_RX, 0, 8'h00);
      offer(CMD_PUSH_RX, 0, 8'hFF);
      offer(CMD_POP_RX, 0, 8'hFF);
      offer(CMD_POP_RX, 0, 8'h00);
      offer(CMD_POP_RX, 2, 8'h00);
      offer(CMD_PUSH_TX, 2, 8'h5A);
      offer(CMD_POP_TX, 2, 8'hA5);
      // size of one on receive, a zero size on transmit acting as one
      enter_phase(9'd1, 9'd0, 4'hF);
      offer(CMD_PUSH_RX, 1, 8'h3C);
      offer(CMD_POP_RX, 1, 8'h00);
      // rx channel 0 pointers sit at 2, beyond the new size: wrap on next step
      offer(CMD_PUSH_RX, 0, 8'hC3);
      offer(CMD_POP_RX, 0, 8'h00);
      offer(CMD_PUSH_TX, 1, 8'h11);
      // oversized register clamps to full depth; size two overflows on second push
      enter_phase(9'd511, 9'd2, 4'hF);
      offer(CMD_PUSH_TX, 0, 8'h01);
      offer(CMD_PUSH_TX, 0, 8'h02);
      offer(CMD_POP_TX, 0, 8'h00);

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin rx_pick = 9'd4;   tx_pick = 9'd3;   end
            1: begin rx_pick = 9'd1;   tx_pick = 9'd256; end
            2: begin rx_pick = 9'd8;   tx_pick = 9'd0;   end
            3: begin rx_pick = 9'd511; tx_pick = 9'd2;   end
            4: begin rx_pick = 9'd5;   tx_pick = 9'd16;  end
            5: begin
               rx_pick = SIZE_W'($urandom_range(1, 32));
               tx_pick = SIZE_W'($urandom_range(1, 32));
            end
            6: begin rx_pick = 9'd2;   tx_pick = 9'd300; end
            default: begin
               rx_pick = SIZE_W'($urandom_range(1, 256));
               tx_pick = 9'd7;
            end
         endcase
         mask_pick = (ph % 3 == 2) ? CHAN_EN_W'($urandom_range(0, 15)) : 4'hF;
         enter_phase(rx_pick, tx_pick, mask_pick);

         case (ph % 4)
            0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_gap_pct = 82; rsp_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  rsp_stall_pct = 82; end
            default: begin send_gap_pct = 25; rsp_stall_pct = 25; end
         endcase

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // hold the receiver off while requests keep coming, so full rises
            if (ph == 4 && n == 10) begin
               hold_ask = 1'b1;
            end
            ch = $urandom_range(0, 3);
            // mostly live channels; leave some noise on any channel
            if ($urandom_range(0, 9) != 0 && live_mask != 0) begin
               while (!live_mask[ch]) begin
                  ch = $urandom_range(0, 3);
               end
            end
            offer(CMD_W'($urandom_range(0, 3)), ch, BYTE_W'($urandom_range(0, 255)));
         end
      end

      send_gap_pct = 0;
      rsp_stall_pct = 0;
      settle();
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/mcsrb_pkg.sv
hw/rtl/mcsrb_front.sv
hw/rtl/mcsrb_back.sv
hw/rtl/multi_channel_serial_ring_buffers.sv
dv/ring_buffers_checker.sv
dv/multi_channel_serial_ring_buffers_tb.sv
